// ===== design/altr_pkg.sv =====
// Package for the arc-length time remap unit: field widths, item kind codes,
// sequencer states and the request/response structs of the shared divider.
// No dependencies.
package altr_pkg;

  localparam int COUNT_W = 9;   // entry_count and search indices
  localparam int IDX_W   = 8;   // entry_index, lower_index
  localparam int VAL_W   = 17;  // Q1.16 values, 65536 = 1.0

  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Shared restoring divider
  localparam int DVD_W  = 25;          // dividend bits shifted in
  localparam int DSR_W  = 17;          // divisor
  localparam int REM_W  = DSR_W + 1;   // partial remainder
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] FRAC_STEPS  = 5'd17;
  localparam logic [STEP_W-1:0] SCALE_STEPS = 5'd25;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem_init;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_FRAC,
    S_FRAC_WAIT,
    S_SCALE,
    S_SCALE_WAIT,
    S_OUT
  } altr_state_t;

endpackage

// ===== design/altr_div.sv =====
// Bit-serial restoring divider shared by the fraction and scaling steps.
// One quotient bit per cycle; depends on altr_pkg.
module altr_div (
  input  logic              clk,
  input  logic              rst,
  input  altr_pkg::div_req_t req,
  output altr_pkg::div_rsp_t rsp
);
  import altr_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [DVD_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic [DVD_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             fits;

  // rem < dsr always holds, so the top remainder bit is free for the shift
  assign trial = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dsr <= req.divisor;
      quo <= '0;
      cnt <= req.steps;
    end else if (busy) begin
      rem <= fits ? diff : trial;
      dvd <= dvd << 1;
      quo <= {quo[DVD_W-2:0], fits};
      cnt <= cnt - STEP_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo[VAL_W-1:0];

endmodule

// ===== design/arc_length_time_remap_unit.sv =====
// Arc-length time remap: write items (kind 0) load one 17-bit entry of the
// arc-length table; query items (kind 1) map a Q1.16 time to the curve
// parameter by binary search over the table and two serial divisions: first
// and last entry reads, one table read per search step through the single
// read port of the table RAM, then 17 and 25 steps in the shared bit-serial
// divider. An equal pair skips the fraction division; a clamped query skips
// both. Fewer than two entries in use make a query pass through.
// The result waits in an output register, so the next item is taken while a
// result is still unclaimed. The table has no reset; entries read before they
// are written hold undefined data. Depends on altr_pkg and altr_div.
module arc_length_time_remap_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [altr_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [altr_pkg::IDX_W-1:0]    entry_index,
  input  logic [altr_pkg::VAL_W-1:0]    entry_value,
  input  logic [altr_pkg::VAL_W-1:0]    query_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [altr_pkg::VAL_W-1:0]    mapped_time,
  output logic [altr_pkg::IDX_W-1:0]    lower_index
);
  import altr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  function automatic logic [COUNT_W-1:0] mid_of(input logic [COUNT_W-1:0] l,
                                                input logic [COUNT_W-1:0] h);
    logic [COUNT_W:0] s;
    s = {1'b0, l} + {1'b0, h};
    return s[COUNT_W:1];
  endfunction

  // Table RAM
  logic [VAL_W-1:0] arc_table [TABLE_DEPTH];
  logic [VAL_W-1:0] rdata;
  logic [AW-1:0]    raddr;
  logic             we;

  // Configuration
  logic [COUNT_W-1:0] entry_count;

  // Sequencer and datapath
  altr_state_t      state, state_next;
  logic [VAL_W-1:0] t;
  logic [COUNT_W-1:0] n, lo, hi, mid, lo_n, hi_n, n_in;
  logic [VAL_W-1:0] a, b, frac, res;
  logic [IDX_W-1:0] lower;
  logic             accept, go_lo, more, frac_nz, out_free;
  logic [VAL_W-1:0] num;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign we       = accept && kind == KIND_WRITE && 32'(entry_index) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (we) begin
      arc_table[AW'(entry_index)] <= entry_value;
    end
    rdata <= arc_table[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  assign n_in = (32'(entry_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : entry_count;

  // Search step: rdata holds the entry at mid of the current bracket
  assign mid   = mid_of(lo, hi);
  assign go_lo = rdata < t;
  assign lo_n  = go_lo ? mid : lo;
  assign hi_n  = go_lo ? hi : mid;
  assign more  = ({1'b0, lo_n} + 10'd1) < {1'b0, hi_n};

  assign frac_nz = (b > a) && (t >= a);
  assign num     = (t > b) ? (b - a) : (t - a);

  always_comb begin
    state_next = state;
    raddr      = '0;
    div_req    = '0;
    case (state)
      S_IDLE: begin
        if (accept && kind == KIND_QUERY) begin
          state_next = (n_in < COUNT_W'(2)) ? S_OUT : S_FIRST;
        end
      end
      S_FIRST: begin
        raddr      = AW'(hi);
        state_next = (t < rdata) ? S_OUT : S_LAST;
      end
      S_LAST: begin
        raddr = AW'(mid);
        if (t > rdata) begin
          state_next = S_OUT;
        end else if (({1'b0, lo} + 10'd1) < {1'b0, hi}) begin
          state_next = S_SEARCH;
        end else begin
          state_next = S_FRAC;
        end
      end
      S_SEARCH: begin
        raddr = AW'(mid_of(lo_n, hi_n));
        if (!more) begin
          state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        // fraction = (num << 16) / (b - a); the top 16 dividend bits give zero
        // quotient bits since num <= b - a, so the remainder starts there
        div_req.start    = frac_nz;
        div_req.rem_init = REM_W'(num[VAL_W-1:1]);
        div_req.dividend = {num[0], {(DVD_W-1){1'b0}}};
        div_req.divisor  = b - a;
        div_req.steps    = FRAC_STEPS;
        state_next       = frac_nz ? S_FRAC_WAIT : S_SCALE;
      end
      S_FRAC_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = DVD_W'({lo, 16'h0000}) + DVD_W'(frac);
        div_req.divisor  = DSR_W'(n - COUNT_W'(1));
        div_req.steps    = SCALE_STEPS;
        state_next       = S_SCALE_WAIT;
      end
      S_SCALE_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        t     <= query_time;
        n     <= n_in;
        lo    <= '0;
        hi    <= n_in - COUNT_W'(1);
        res   <= query_time;
        lower <= '0;
      end
      S_FIRST: begin
        a   <= rdata;
        res <= '0;
      end
      S_LAST: begin
        b   <= rdata;
        res <= ONE_Q16;
      end
      S_SEARCH: begin
        lo <= lo_n;
        hi <= hi_n;
        if (go_lo) begin
          a <= rdata;
        end else begin
          b <= rdata;
        end
      end
      S_FRAC: begin
        frac <= '0;
      end
      S_FRAC_WAIT: begin
        if (div_rsp.done) begin
          frac <= div_rsp.quotient;
        end
      end
      S_SCALE_WAIT: begin
        if (div_rsp.done) begin
          res   <= div_rsp.quotient;
          lower <= lo[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  altr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      mapped_time <= res;
      lower_index <= lower;
    end
  end

endmodule

// ===== design/altr_check.sv =====
// Port-level checks for arc_length_time_remap_unit, attached by bind.
// Depends on altr_pkg.
module altr_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [altr_pkg::VAL_W-1:0]   mapped_time,
  input logic [altr_pkg::IDX_W-1:0]   lower_index
);
  import altr_pkg::*;

  // a result held back stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mapped_time) && $stable(lower_index))
    else $error("result changed while stalled");

  // only a pass-through query can show a time above 1.0, and it has no bracket
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && mapped_time > ONE_Q16 |-> lower_index == '0)
    else $error("mapped_time above 1.0 with a bracket");

  // a query keeps the block busy past its accept cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_QUERY |=> !in_ready)
    else $error("query did not occupy the block");

  // a table write finishes in its accept cycle
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_WRITE |=> in_ready)
    else $error("write item stalled the input");

endmodule

bind arc_length_time_remap_unit altr_check u_altr_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .mapped_time (mapped_time),
  .lower_index (lower_index)
);

// ===== test/tb_arc_length_time_remap_unit.sv =====
// Testbench for arc_length_time_remap_unit: directed table of writes, queries
// and count changes, then random table loads and queries checked by a predictor.
// Depends on altr_pkg and the arc_length_time_remap_unit RTL.
module tb_arc_length_time_remap_unit;
  import altr_pkg::*;

  localparam int TABLE_DEPTH   = 256;
  localparam int ITEM_TARGET   = 1000;
  localparam int SETTLE_CYCLES = 80;    // longer than the longest query
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DIR_ROWS      = 23;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_op_t;

  typedef struct packed {
    row_op_t            op;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   value;
    logic [VAL_W-1:0]   t;
    logic               pinned;  // expected result given in the row
    logic [VAL_W-1:0]   exp_mapped;
    logic [IDX_W-1:0]   exp_lower;
  } dir_row_t;

  typedef struct packed {
    logic [VAL_W-1:0] mapped;
    logic [IDX_W-1:0] lower;
  } remap_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic [IDX_W-1:0]   entry_index;
  logic [VAL_W-1:0]   entry_value;
  logic [VAL_W-1:0]   query_time;
  logic               out_valid;
  logic               out_ready;
  logic [VAL_W-1:0]   mapped_time;
  logic [IDX_W-1:0]   lower_index;

  // travels with the item so the scoreboard can use a hand-written answer
  logic               pinned;
  logic [VAL_W-1:0]   pinned_mapped;
  logic [IDX_W-1:0]   pinned_lower;

  // scoreboard copy of the block state
  logic [VAL_W-1:0]   arc_shadow [TABLE_DEPTH];
  logic [COUNT_W-1:0] count_shadow = '0;
  remap_t             expected_remaps [$];

  // what the stimulus has written so far, used to keep queries on written slots
  logic [VAL_W-1:0]   staged_arcs [TABLE_DEPTH];
  bit                 staged_written [TABLE_DEPTH];

  int  error_count  = 0;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  bit  no_gap       = 1'b0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // count 0 after reset: pass-through
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'h1FFFF, 1'b1, 17'h1FFFF, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd0,     1'b1, 17'd0,     8'd0},
    '{ROW_CFG,   9'd1,   8'd0,   17'd0,       17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd12345, 1'b1, 17'd12345, 8'd0},
    // slots 0 and 1 form an equal pair
    '{ROW_WRITE, 9'd0,   8'd0,   17'd1000,    17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_WRITE, 9'd0,   8'd1,   17'd1000,    17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_WRITE, 9'd0,   8'd2,   17'd40000,   17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_WRITE, 9'd0,   8'd3,   17'h10000,   17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_WRITE, 9'd0,   8'd255, 17'h1FFFF,   17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_WRITE, 9'd0,   8'd170, 17'h0AAAA,   17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_WRITE, 9'd0,   8'd85,  17'h15555,   17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_CFG,   9'd4,   8'd0,   17'd0,       17'd0,     1'b0, 17'd0,     8'd0},
    // below first, above last (query beyond 1.0)
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd999,   1'b1, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd65537, 1'b1, 17'h10000, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd1000,  1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'h10000, 1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd20000, 1'b0, 17'd0,     8'd0},
    // table no longer nondecreasing
    '{ROW_WRITE, 9'd0,   8'd2,   17'd500,     17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd30000, 1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd800,   1'b1, 17'd0,     8'd0},
    '{ROW_CFG,   9'd2,   8'd0,   17'd0,       17'd0,     1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'd1000,  1'b0, 17'd0,     8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   17'd0,       17'h1FFFF, 1'b1, 17'h10000, 8'd0}
  };

  arc_length_time_remap_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .query_time  (query_time),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mapped_time (mapped_time),
    .lower_index (lower_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Inverse lookup: binary search for the bracketing pair, then two truncating
  // divisions. The search keeps table[lo] <= t <= table[hi].
  function automatic remap_t remap_time(input logic [VAL_W-1:0] t);
    remap_t      r;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] tw;
    logic [63:0] num;
    logic [63:0] frac;
    logic [63:0] q;
    n = (32'(count_shadow) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(count_shadow);
    r.mapped = t;
    r.lower  = '0;
    if (n < 2) return r;
    if (t < arc_shadow[0]) begin
      r.mapped = '0;
      return r;
    end
    if (t > arc_shadow[n-1]) begin
      r.mapped = ONE_Q16;
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      if (arc_shadow[mid] < t) lo = mid;
      else hi = mid;
    end
    a    = 64'(arc_shadow[lo]);
    b    = 64'(arc_shadow[hi]);
    tw   = 64'(t);
    frac = '0;
    if (b > a && tw >= a) begin
      num  = (tw > b) ? b - a : tw - a;
      frac = (num << 16) / (b - a);
    end
    q = ((64'(lo) << 16) + frac) / 64'(n - 1);
    r.mapped = q[VAL_W-1:0];
    r.lower  = lo[IDX_W-1:0];
    return r;
  endfunction

  function automatic void log_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endfunction

  // scoreboard: results are checked before the same edge's item is predicted
  always @(posedge clk) begin : scoreboard
    remap_t want;
    bit     busy;
    if (!rst) begin
      busy = 1'b0;
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (expected_remaps.size() == 0) begin
          log_error($sformatf("result with no query pending: mapped_time %0d lower_index %0d",
                              mapped_time, lower_index));
        end else begin
          want = expected_remaps.pop_front();
          if (mapped_time !== want.mapped || lower_index !== want.lower)
            log_error($sformatf("mismatch: expected mapped_time %0d lower_index %0d, got %0d %0d",
                                want.mapped, want.lower, mapped_time, lower_index));
        end
      end
      if (in_valid && in_ready) begin
        busy = 1'b1;
        if (kind == KIND_WRITE) begin
          arc_shadow[entry_index] = entry_value;
        end else if (pinned) begin
          want.mapped = pinned_mapped;
          want.lower  = pinned_lower;
          expected_remaps.push_back(want);
        end else begin
          expected_remaps.push_back(remap_time(query_time));
        end
      end
      if (cfg_we) begin
        busy = 1'b1;
        count_shadow = cfg_data;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : receiver
    int stall;
    int streak;
    streak = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills up and backs up the input
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (streak > 0) begin
        streak--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        streak = 24;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // valid stays high across back-to-back items; lowered only for a gap
  task automatic send_item(input logic k, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] t,
                           input logic pin, input logic [VAL_W-1:0] pin_mapped,
                           input logic [IDX_W-1:0] pin_lower);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    entry_index   <= idx;
    entry_value   <= val;
    query_time    <= t;
    pinned        <= pin;
    pinned_mapped <= pin_mapped;
    pinned_lower  <= pin_lower;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    send_item(KIND_WRITE, idx, val, VAL_W'($urandom_range(0, 131071)), 1'b0, '0, '0);
    staged_arcs[idx]    = val;
    staged_written[idx] = 1'b1;
  endtask

  // count changes only with the block drained and settled
  task automatic set_entry_count(input logic [COUNT_W-1:0] c);
    in_valid <= 1'b0;
    while (expected_remaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] c, input int len);
    int               n;
    int               i;
    int               j;
    int               pick;
    int               probe;
    bit               refill;
    bit               scrambled;
    int unsigned      arc;
    int unsigned      step_max;
    logic [VAL_W-1:0] t;
    set_entry_count(c);
    n = (int'(c) > TABLE_DEPTH) ? TABLE_DEPTH : int'(c);
    no_gap = ($urandom_range(0, 3) == 0);
    // small tables get a fresh load; larger ones only if a used slot is unwritten
    refill = (n <= 32);
    for (i = 0; i < n; i++)
      if (!staged_written[i]) refill = 1'b1;
    if (n >= 2 && refill) begin
      scrambled = ($urandom_range(0, 9) == 0);
      step_max  = 131072 / n;
      arc       = $urandom_range(0, 4096);
      for (i = 0; i < n; i++) begin
        if (scrambled) begin
          arc = $urandom_range(0, 131071);
        end else if ($urandom_range(0, 4) != 0) begin
          arc += $urandom_range(0, step_max);
          if (arc > 65536) arc = 65536;
        end
        send_write(i[IDX_W-1:0], arc[VAL_W-1:0]);
      end
    end
    if (!hold_done && items_sent >= 400) begin
      hold_req  = 1'b1;
      hold_done = 1'b1;
    end
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 2) == 0) arc = $urandom_range(0, 131071);
        else arc = $urandom_range(0, 65536);
        send_write(IDX_W'($urandom_range(0, 255)), arc[VAL_W-1:0]);
      end else begin
        pick  = $urandom_range(0, 19);
        probe = (n >= 2) ? $urandom_range(0, n - 1) : 0;
        if (pick <= 10) begin
          t = VAL_W'($urandom_range(0, 65536));
        end else if (pick <= 14) begin
          t = staged_arcs[probe];
        end else if (pick <= 17) begin
          arc = staged_arcs[probe] + $urandom_range(0, 4);
          arc = (arc >= 2) ? arc - 2 : 0;
          t = arc[VAL_W-1:0];
        end else begin
          t = VAL_W'($urandom_range(0, 131071));
        end
        send_item(KIND_QUERY, '0, '0, t, 1'b0, '0, '0);
      end
    end
  endtask

  initial begin : stimulus
    int                 phase;
    int                 sel;
    logic [COUNT_W-1:0] c;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    kind          = KIND_WRITE;
    entry_index   = '0;
    entry_value   = '0;
    query_time    = '0;
    pinned        = 1'b0;
    pinned_mapped = '0;
    pinned_lower  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_CFG:   set_entry_count(directed_rows[i].count);
        ROW_WRITE: send_write(directed_rows[i].idx, directed_rows[i].value);
        default:   send_item(KIND_QUERY, '0, '0, directed_rows[i].t, directed_rows[i].pinned,
                             directed_rows[i].exp_mapped, directed_rows[i].exp_lower);
      endcase
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (phase == 0) c = COUNT_W'(2);
      else if (phase == 1) c = COUNT_W'(TABLE_DEPTH);
      else if (phase == 2) c = '0;
      else if (sel == 0) c = COUNT_W'(1);
      else if (sel == 1) c = '0;
      else if (sel == 2) c = COUNT_W'(TABLE_DEPTH);
      else if (sel == 3) c = COUNT_W'($urandom_range(257, 511));
      else if (sel <= 5) c = COUNT_W'($urandom_range(33, 255));
      else c = COUNT_W'($urandom_range(2, 32));
      run_phase(c, $urandom_range(8, 40));
      phase++;
    end
    // count beyond the table depth
    run_phase(9'd511, 20);

    in_valid <= 1'b0;
    while (expected_remaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_remaps.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
